[rtl/ocp_pkg.sv]
// Shared types, constants and helper functions for the orbit camera pose unit.
// Used by ocp_front, ocp_queue, ocp_back and orbit_camera_pose_unit; no dependencies.
`default_nettype none

package ocp_pkg;

    // Iteration counts of the shared CORDIC and of the bit-serial square root.
    localparam int CORDIC_STEPS = 32;
    localparam int SQRT_STEPS   = 34;
    localparam int CNT_W        = 6;

    // Packed stream widths.
    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 232;

    // Request kinds.
    localparam logic [1:0] REQ_SET_POS   = 2'd0;
    localparam logic [1:0] REQ_SET_ORBIT = 2'd1;
    localparam logic [1:0] REQ_READ_VIEW = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TARGET_X = 2'd0;
    localparam logic [1:0] CFG_TARGET_Y = 2'd1;
    localparam logic [1:0] CFG_TARGET_Z = 2'd2;

    // Angle constants in Q3.29 and the CORDIC start value in Q30.
    localparam logic signed [33:0] PI_Q29       = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q29  = 34'sd843314857;
    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;

    localparam logic [32:0] RANGE_RESET = 33'd655360;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [32:0]        new_range;
        logic signed [31:0] new_elevation;
        logic signed [31:0] new_azimuth;
    } t_req;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SQRT,
        ST_VNORM,
        ST_VROT,
        ST_ROT,
        ST_PROD,
        ST_ROW,
        ST_ROWOUT,
        ST_POSE
    } t_state;

    // Arctangent of 2^-i in Q3.29.
    function automatic logic signed [33:0] atan_q29(input logic [CNT_W-1:0] i);
        logic signed [33:0] v;
        unique case (i)
            6'd0: v = 34'sd421657428;
            6'd1: v = 34'sd248918915;
            6'd2: v = 34'sd131521918;
            6'd3: v = 34'sd66762579;
            6'd4: v = 34'sd33510843;
            6'd5: v = 34'sd16771758;
            6'd6: v = 34'sd8387925;
            6'd7: v = 34'sd4194219;
            6'd8: v = 34'sd2097141;
            6'd9: v = 34'sd1048575;
            default: v = (i <= 6'd29) ? (34'sd1 <<< (6'd29 - i)) : 34'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/ocp_queue.sv]
// Two-entry request queue between the front and the back of the pose unit.
// Depends on ocp_pkg for the request type.
`default_nettype none

module ocp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  ocp_pkg::t_req      i_req,
    output logic               o_full,
    input  wire logic          i_pop,
    output ocp_pkg::t_req      o_req,
    output logic               o_empty
);
    import ocp_pkg::*;

    t_req       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_req   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_req;
        end
    end

endmodule

`default_nettype wire

[rtl/ocp_front.sv]
// Front end: accepts request transfers, drops the unused code and holds the target registers.
// Depends on ocp_pkg.
`default_nettype none

module ocp_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [ocp_pkg::IN_DATA_W-1:0]  i_in_data,
    input  wire logic [1:0]                     i_in_user,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data,
    input  wire logic                           i_queue_full,
    output logic                                o_push,
    output ocp_pkg::t_req                       o_req,
    output ocp_pkg::t_cfg                       o_cfg
);
    import ocp_pkg::*;

    t_cfg r_cfg;
    logic in_xfer;

    assign o_in_ready  = !i_queue_full;
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && !i_queue_full;

    // The unused request code is accepted but never reaches the back end.
    assign o_push = in_xfer && (i_in_user == REQ_SET_POS || i_in_user == REQ_SET_ORBIT ||
                                i_in_user == REQ_READ_VIEW);

    assign o_req.kind          = i_in_user;
    assign o_req.pos_x         = i_in_data[31:0];
    assign o_req.pos_y         = i_in_data[63:32];
    assign o_req.pos_z         = i_in_data[95:64];
    assign o_req.new_range     = i_in_data[128:96];
    assign o_req.new_elevation = i_in_data[160:129];
    assign o_req.new_azimuth   = i_in_data[192:161];
    assign o_cfg               = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TARGET_X: r_cfg.target_x <= i_cfg_data;
                CFG_TARGET_Y: r_cfg.target_y <= i_cfg_data;
                CFG_TARGET_Z: r_cfg.target_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/ocp_back.sv]
// Back end: pose sequencer with a shared multiplier, bit-serial square root and CORDIC,
// plus the result register. Depends on ocp_pkg.
`default_nettype none

module ocp_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  ocp_pkg::t_req                       i_req,
    input  wire logic                           i_queue_empty,
    output logic                                o_pop,
    input  ocp_pkg::t_cfg                       i_cfg,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [ocp_pkg::OUT_DATA_W-1:0]      o_out_data,
    output logic                                o_out_last
);
    import ocp_pkg::*;

    function automatic logic signed [33:0] rnd30(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = v + 68'sd536870912;
        return 34'(t >>> 30);
    endfunction

    function automatic logic signed [31:0] rnd14(input logic signed [33:0] v);
        logic signed [34:0] t;
        t = 35'(v) + 35'sd8192;
        return 32'(t >>> 14);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] s;
        if (v > 42'sd2147483647) begin
            s = 32'sh7fffffff;
        end else if (v < -42'sd2147483648) begin
            s = 32'sh80000000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_pass, n_pass;
    logic                   r_flip, n_flip;
    logic [1:0]             r_row, n_row;
    logic [32:0]            r_range, n_range;
    logic signed [31:0]     r_elev, n_elev;
    logic signed [31:0]     r_azim, n_azim;
    logic                   r_ovalid, n_ovalid;

    logic signed [33:0]     r_dx, n_dx, r_dy, n_dy, r_dz, n_dz;
    logic signed [67:0]     r_prod, n_prod;
    logic signed [69:0]     r_acc, n_acc;
    logic [65:0]            r_hsum, n_hsum;
    logic [67:0]            r_rad, n_rad;
    logic [36:0]            r_rem, n_rem;
    logic [33:0]            r_root, n_root;
    logic signed [63:0]     r_vx, n_vx, r_vy, n_vy;
    logic signed [33:0]     r_z, n_z;
    logic signed [33:0]     r_ct, n_ct, r_st, n_st, r_cp, n_cp, r_sp, n_sp;
    logic signed [33:0]     r_m10, n_m10, r_m12, n_m12, r_m20, n_m20, r_m22, n_m22;
    logic [1:0]             r_orow, n_orow;
    logic signed [31:0]     r_oc0, n_oc0, r_oc1, n_oc1, r_oc2, n_oc2, r_oc3, n_oc3;
    logic [32:0]            r_orange, n_orange;
    logic signed [31:0]     r_oelev, n_oelev, r_oazim, n_oazim;
    logic                   r_olast, n_olast;

    logic signed [33:0]     mul_a, mul_b;
    logic                   out_free;

    // Square root step: one result bit per cycle.
    logic [38:0]            sq_rem2, sq_trial;
    logic                   sq_ge;
    logic [36:0]            sq_rem;
    logic [33:0]            sq_root;

    assign sq_rem2  = {r_rem, r_rad[67:66]};
    assign sq_trial = {3'b000, r_root, 2'b01};
    assign sq_ge    = (sq_rem2 >= sq_trial);
    assign sq_rem   = sq_ge ? 37'(sq_rem2 - sq_trial) : sq_rem2[36:0];
    assign sq_root  = {r_root[32:0], sq_ge};

    // CORDIC step shared by vectoring and rotation.
    logic signed [63:0]     c_sx, c_sy;
    logic signed [33:0]     c_at;
    logic [63:0]            c_mx, c_my, c_m;
    logic signed [63:0]     vec_x, vec_y, rot_x, rot_y;
    logic signed [33:0]     vec_z, rot_z;

    assign c_sx = r_vx >>> r_cnt;
    assign c_sy = r_vy >>> r_cnt;
    assign c_at = atan_q29(r_cnt);
    assign c_mx = r_vx[63] ? 64'(-r_vx) : 64'(r_vx);
    assign c_my = r_vy[63] ? 64'(-r_vy) : 64'(r_vy);
    assign c_m  = (c_mx > c_my) ? c_mx : c_my;

    assign vec_x = r_vy[63] ? (r_vx - c_sy) : (r_vx + c_sy);
    assign vec_y = r_vy[63] ? (r_vy + c_sx) : (r_vy - c_sx);
    assign vec_z = r_vy[63] ? (r_z - c_at) : (r_z + c_at);
    assign rot_x = r_z[33] ? (r_vx + c_sy) : (r_vx - c_sy);
    assign rot_y = r_z[33] ? (r_vy - c_sx) : (r_vy + c_sx);
    assign rot_z = r_z[33] ? (r_z + c_at) : (r_z - c_at);

    // Final angle clamps.
    logic signed [33:0]     z_pi, z_half;
    assign z_pi   = (vec_z > PI_Q29) ? PI_Q29 : ((vec_z < -PI_Q29) ? -PI_Q29 : vec_z);
    assign z_half = (z_pi > HALF_PI_Q29) ? HALF_PI_Q29 :
                    ((z_pi < -HALF_PI_Q29) ? -HALF_PI_Q29 : z_pi);

    // Rotation setup: angles past a quarter turn are moved by pi and the result negated.
    logic signed [33:0]     sc_a, sc_start;
    logic                   sc_hi, sc_lo;
    assign sc_a     = (r_state == ST_IDLE) ? 34'(r_elev) : 34'(r_azim);
    assign sc_hi    = (sc_a > HALF_PI_Q29);
    assign sc_lo    = (sc_a < -HALF_PI_Q29);
    assign sc_start = sc_hi ? (sc_a - PI_Q29) : (sc_lo ? (sc_a + PI_Q29) : sc_a);

    logic signed [33:0]     rot_c, rot_s;
    assign rot_c = r_flip ? -rot_x[33:0] : rot_x[33:0];
    assign rot_s = r_flip ? -rot_y[33:0] : rot_y[33:0];

    // Current view matrix row.
    logic signed [33:0]     row_e0, row_e1, row_e2;
    always_comb begin
        unique case (r_row)
            2'd0: begin
                row_e0 = r_cp;
                row_e1 = '0;
                row_e2 = -r_sp;
            end
            2'd1: begin
                row_e0 = r_m10;
                row_e1 = r_ct;
                row_e2 = r_m12;
            end
            2'd2: begin
                row_e0 = r_m20;
                row_e1 = r_st;
                row_e2 = r_m22;
            end
            default: begin
                row_e0 = '0;
                row_e1 = '0;
                row_e2 = '0;
            end
        endcase
    end

    // Translation column.
    logic signed [69:0]     tr_sh;
    logic signed [41:0]     tr_val;
    assign tr_sh  = (r_acc + 70'sd536870912) >>> 30;
    assign tr_val = -42'(tr_sh) - ((r_row == 2'd2) ? $signed({9'b0, r_range}) : 42'sd0);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pass   = r_pass;
        n_flip   = r_flip;
        n_row    = r_row;
        n_range  = r_range;
        n_elev   = r_elev;
        n_azim   = r_azim;
        n_ovalid = r_ovalid;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_dz     = r_dz;
        n_acc    = r_acc;
        n_hsum   = r_hsum;
        n_rad    = r_rad;
        n_rem    = r_rem;
        n_root   = r_root;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_z      = r_z;
        n_ct     = r_ct;
        n_st     = r_st;
        n_cp     = r_cp;
        n_sp     = r_sp;
        n_m10    = r_m10;
        n_m12    = r_m12;
        n_m20    = r_m20;
        n_m22    = r_m22;
        n_orow   = r_orow;
        n_oc0    = r_oc0;
        n_oc1    = r_oc1;
        n_oc2    = r_oc2;
        n_oc3    = r_oc3;
        n_orange = r_orange;
        n_oelev  = r_oelev;
        n_oazim  = r_oazim;
        n_olast  = r_olast;
        mul_a    = '0;
        mul_b    = '0;
        o_pop    = 1'b0;

        out_free = !r_ovalid || i_out_ready;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (!i_queue_empty) begin
                    o_pop  = 1'b1;
                    n_cnt  = '0;
                    n_pass = 1'b0;
                    unique case (i_req.kind)
                        REQ_SET_POS: begin
                            n_dx    = 34'(i_req.pos_x) - 34'(i_cfg.target_x);
                            n_dy    = 34'(i_req.pos_y) - 34'(i_cfg.target_y);
                            n_dz    = 34'(i_req.pos_z) - 34'(i_cfg.target_z);
                            n_state = ST_SQUARE;
                        end
                        REQ_SET_ORBIT: begin
                            n_range = i_req.new_range;
                            n_elev  = i_req.new_elevation;
                            n_azim  = i_req.new_azimuth;
                            n_state = ST_POSE;
                        end
                        REQ_READ_VIEW: begin
                            n_vx    = 64'(INV_GAIN_Q30);
                            n_vy    = '0;
                            n_z     = sc_start;
                            n_flip  = sc_hi || sc_lo;
                            n_state = ST_ROT;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SQUARE: begin
                n_cnt = r_cnt + 1'b1;
                unique case (r_cnt)
                    6'd0: begin
                        if (r_dx == 0 && r_dy == 0 && r_dz == 0) begin
                            n_range = '0;
                            n_elev  = '0;
                            n_azim  = '0;
                            n_state = ST_POSE;
                        end
                        mul_a = r_dx;
                        mul_b = r_dx;
                    end
                    6'd1: begin
                        n_acc = 70'(r_prod);
                        mul_a = r_dz;
                        mul_b = r_dz;
                    end
                    6'd2: begin
                        n_acc  = r_acc + 70'(r_prod);
                        n_hsum = 66'(r_acc + 70'(r_prod));
                        mul_a  = r_dy;
                        mul_b  = r_dy;
                    end
                    6'd3: begin
                        n_rad   = 68'(r_acc + 70'(r_prod));
                        n_rem   = '0;
                        n_root  = '0;
                        n_cnt   = '0;
                        n_pass  = 1'b0;
                        n_state = ST_SQRT;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end

            ST_SQRT: begin
                n_rad  = r_rad << 2;
                n_rem  = sq_rem;
                n_root = sq_root;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    if (!r_pass) begin
                        n_range = sq_root[32:0];
                        if (r_dx == 0 && r_dz == 0) begin
                            n_elev  = r_dy > 0 ? 32'(HALF_PI_Q29) : 32'(-HALF_PI_Q29);
                            n_azim  = '0;
                            n_state = ST_POSE;
                        end else begin
                            n_rad  = {2'b00, r_hsum};
                            n_rem  = '0;
                            n_root = '0;
                            n_cnt  = '0;
                            n_pass = 1'b1;
                        end
                    end else begin
                        // Elevation: atan2(dy, horizontal distance); the distance is never negative.
                        n_vx    = 64'(sq_root);
                        n_vy    = 64'(r_dy);
                        n_z     = '0;
                        n_pass  = 1'b0;
                        n_state = ST_VNORM;
                    end
                end
            end

            ST_VNORM: begin
                if (c_m < 64'h0080_0000_0000_0000) begin
                    n_vx = r_vx <<< 4;
                    n_vy = r_vy <<< 4;
                end else if (c_m < 64'h0800_0000_0000_0000) begin
                    n_vx = r_vx <<< 1;
                    n_vy = r_vy <<< 1;
                end else begin
                    n_cnt   = '0;
                    n_state = ST_VROT;
                end
            end

            ST_VROT: begin
                n_vx  = vec_x;
                n_vy  = vec_y;
                n_z   = vec_z;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CORDIC_LAST) begin
                    if (!r_pass) begin
                        n_elev = 32'(z_half);
                        // Azimuth: atan2(dx, dz), folded into the right half plane.
                        if (r_dz < 0) begin
                            n_z  = (r_dx >= 0) ? PI_Q29 : -PI_Q29;
                            n_vx = -64'(r_dz);
                            n_vy = -64'(r_dx);
                        end else begin
                            n_z  = '0;
                            n_vx = 64'(r_dz);
                            n_vy = 64'(r_dx);
                        end
                        n_pass  = 1'b1;
                        n_state = ST_VNORM;
                    end else begin
                        n_azim  = 32'(z_pi);
                        n_state = ST_POSE;
                    end
                end
            end

            ST_ROT: begin
                n_vx  = rot_x;
                n_vy  = rot_y;
                n_z   = rot_z;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CORDIC_LAST) begin
                    n_cnt = '0;
                    if (!r_pass) begin
                        n_ct   = rot_c;
                        n_st   = rot_s;
                        n_vx   = 64'(INV_GAIN_Q30);
                        n_vy   = '0;
                        n_z    = sc_start;
                        n_flip = sc_hi || sc_lo;
                        n_pass = 1'b1;
                    end else begin
                        n_cp    = rot_c;
                        n_sp    = rot_s;
                        n_state = ST_PROD;
                    end
                end
            end

            ST_PROD: begin
                n_cnt = r_cnt + 1'b1;
                unique case (r_cnt)
                    6'd0: begin
                        mul_a = r_st;
                        mul_b = r_sp;
                    end
                    6'd1: begin
                        n_m10 = rnd30(-r_prod);
                        mul_a = r_st;
                        mul_b = r_cp;
                    end
                    6'd2: begin
                        n_m12 = rnd30(-r_prod);
                        mul_a = r_ct;
                        mul_b = r_sp;
                    end
                    6'd3: begin
                        n_m20 = rnd30(r_prod);
                        mul_a = r_ct;
                        mul_b = r_cp;
                    end
                    6'd4: begin
                        n_m22   = rnd30(r_prod);
                        n_row   = 2'd0;
                        n_cnt   = '0;
                        n_state = ST_ROW;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end

            ST_ROW: begin
                n_cnt = r_cnt + 1'b1;
                unique case (r_cnt)
                    6'd0: begin
                        mul_a = row_e0;
                        mul_b = 34'(i_cfg.target_x);
                    end
                    6'd1: begin
                        n_acc = 70'(r_prod);
                        mul_a = row_e1;
                        mul_b = 34'(i_cfg.target_y);
                    end
                    6'd2: begin
                        n_acc = r_acc + 70'(r_prod);
                        mul_a = row_e2;
                        mul_b = 34'(i_cfg.target_z);
                    end
                    6'd3: begin
                        n_acc   = r_acc + 70'(r_prod);
                        n_state = ST_ROWOUT;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end

            ST_ROWOUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_orow   = r_row;
                    n_oc0    = rnd14(row_e0);
                    n_oc1    = rnd14(row_e1);
                    n_oc2    = rnd14(row_e2);
                    n_oc3    = sat32(tr_val);
                    n_orange = r_range;
                    n_oelev  = r_elev;
                    n_oazim  = r_azim;
                    n_olast  = (r_row == 2'd2);
                    n_cnt    = '0;
                    if (r_row == 2'd2) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_row   = r_row + 2'd1;
                        n_state = ST_ROW;
                    end
                end
            end

            ST_POSE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_orow   = 2'd0;
                    n_oc0    = '0;
                    n_oc1    = '0;
                    n_oc2    = '0;
                    n_oc3    = '0;
                    n_orange = r_range;
                    n_oelev  = r_elev;
                    n_oazim  = r_azim;
                    n_olast  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase

        n_prod = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_pass   <= 1'b0;
            r_flip   <= 1'b0;
            r_row    <= '0;
            r_range  <= RANGE_RESET;
            r_elev   <= '0;
            r_azim   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pass   <= n_pass;
            r_flip   <= n_flip;
            r_row    <= n_row;
            r_range  <= n_range;
            r_elev   <= n_elev;
            r_azim   <= n_azim;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_dz     <= n_dz;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_hsum   <= n_hsum;
        r_rad    <= n_rad;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_z      <= n_z;
        r_ct     <= n_ct;
        r_st     <= n_st;
        r_cp     <= n_cp;
        r_sp     <= n_sp;
        r_m10    <= n_m10;
        r_m12    <= n_m12;
        r_m20    <= n_m20;
        r_m22    <= n_m22;
        r_orow   <= n_orow;
        r_oc0    <= n_oc0;
        r_oc1    <= n_oc1;
        r_oc2    <= n_oc2;
        r_oc3    <= n_oc3;
        r_orange <= n_orange;
        r_oelev  <= n_oelev;
        r_oazim  <= n_oazim;
        r_olast  <= n_olast;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_last  = r_olast;
    assign o_out_data  = {5'b00000, r_oazim, r_oelev, r_orange, r_oc3, r_oc2, r_oc1, r_oc0,
                          r_orow};

endmodule

`default_nettype wire

[rtl/orbit_camera_pose_unit.sv]
// Orbit camera pose unit. A request transfer enters the two-entry queue. From the pop, a
// set-from-position runs two 34-step square roots and two 32-step CORDIC vectoring passes, each
// after a normalization; a zero offset skips them and a vertical one runs the first root only.
// A pose load stores the pose; a view read runs two 32-step CORDIC rotations, four products
// and three rows. Output stalls add to each. One request is worked on at a time. Synchronous
// active-low reset: range 10.0, angles and targets zero, queue and output register empty.
`default_nettype none

module orbit_camera_pose_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Request stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata from bit 0: pos_x, pos_y, pos_z, new_range, new_elevation, new_azimuth, zero pad.
    input  wire logic [ocp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: req_type.
    input  wire logic [1:0]                         s_axis_tuser,
    // Result stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata from bit 0: row_index, col0, col1, col2, col3, cur_range, cur_elevation,
    // cur_azimuth, zero pad.
    output logic [ocp_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    output logic                                    m_axis_tlast,
    // Target register writes.
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [1:0]                         i_cfg_index,
    input  wire logic [31:0]                        i_cfg_data
);
    import ocp_pkg::*;

    // The front end classifies each transfer: the unused request code is swallowed and
    // the rest go into the queue. The target registers live in the front end as well.
    t_req front_req;
    t_req queue_req;
    t_cfg cfg;
    logic push;
    logic pop;
    logic queue_full;
    logic queue_empty;

    ocp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_req        (front_req),
        .o_cfg        (cfg)
    );

    // The queue decouples the two sides so that each can stall on its own.
    ocp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_req   (queue_req),
        .o_empty (queue_empty)
    );

    // The back end sequences the arithmetic and owns the output register, which holds a
    // finished result while the next computation proceeds until a new result is due.
    ocp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (queue_req),
        .i_queue_empty (queue_empty),
        .o_pop         (pop),
        .i_cfg         (cfg),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

[test/tb_orbit_camera_pose_unit.sv]
// Self-checking testbench for orbit_camera_pose_unit: pose setting from positions, direct
// pose loads and view matrix reads, checked against an in-bench integer predictor.
// Depends on ocp_pkg and the orbit_camera_pose_unit RTL only.
`default_nettype none

// Scoreboard: holds the camera pose and target, predicts the results of each accepted
// request and checks the result transfers against them in order.
class pose_scoreboard;
    logic [32:0]        range_q;
    logic signed [63:0] elev_q, azim_q;
    logic signed [63:0] tgt_x, tgt_y, tgt_z;
    logic [231:0]       pending[$];
    logic               pending_last[$];
    int                 errors;
    int                 results_seen;

    function new();
        range_q = ocp_pkg::RANGE_RESET;
        elev_q = 0;
        azim_q = 0;
        tgt_x = 0;
        tgt_y = 0;
        tgt_z = 0;
        errors = 0;
        results_seen = 0;
    endfunction

    function void write_target(logic [1:0] idx, logic [31:0] val);
        if (idx == ocp_pkg::CFG_TARGET_X) tgt_x = $signed(val);
        else if (idx == ocp_pkg::CFG_TARGET_Y) tgt_y = $signed(val);
        else if (idx == ocp_pkg::CFG_TARGET_Z) tgt_z = $signed(val);
    endfunction

    function automatic logic signed [63:0] arctan_step(int i);
        logic signed [63:0] tab[10];
        tab = '{421657428, 248918915, 131521918, 66762579, 33510843,
                16771758, 8387925, 4194219, 2097141, 1048575};
        if (i < 10) return tab[i];
        if (i <= 29) return 64'sd1 <<< (29 - i);
        return 0;
    endfunction

    function automatic logic signed [63:0] round_q(logic signed [63:0] v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [63:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] root_floor(logic [127:0] sq);
        logic [63:0]  r;
        logic [63:0]  c;
        r = 0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= sq) r = c;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] vector_angle(logic signed [63:0] y,
                                                        logic signed [63:0] x);
        logic signed [63:0] z, nx, ny;
        logic [63:0]        m, ax, ay;
        int                 s;
        z = 0;
        s = 0;
        if (x < 0) begin
            z = (y >= 0) ? 64'(ocp_pkg::PI_Q29) : -64'(ocp_pkg::PI_Q29);
            x = -x;
            y = -y;
        end
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m = (ax > ay) ? ax : ay;
        while (m < (64'd1 << 59)) begin
            m = m << 1;
            s++;
        end
        x = x <<< s;
        y = y <<< s;
        for (int i = 0; i < ocp_pkg::CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += arctan_step(i);
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= arctan_step(i);
            end
            x = nx;
            y = ny;
        end
        if (z > ocp_pkg::PI_Q29) z = ocp_pkg::PI_Q29;
        if (z < -ocp_pkg::PI_Q29) z = -ocp_pkg::PI_Q29;
        return z;
    endfunction

    function automatic void cos_sin(logic signed [63:0] a, output logic signed [63:0] c,
                                    output logic signed [63:0] s);
        logic signed [63:0] x, y, nx, ny;
        logic               flip;
        x = ocp_pkg::INV_GAIN_Q30;
        y = 0;
        flip = 0;
        if (a > ocp_pkg::HALF_PI_Q29) begin
            a -= ocp_pkg::PI_Q29; flip = 1;
        end else if (a < -ocp_pkg::HALF_PI_Q29) begin
            a += ocp_pkg::PI_Q29; flip = 1;
        end
        for (int i = 0; i < ocp_pkg::CORDIC_STEPS; i++) begin
            if (a >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); a -= arctan_step(i);
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); a += arctan_step(i);
            end
            x = nx;
            y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void push_result(logic [1:0] row, logic signed [63:0] c0,
                                        logic signed [63:0] c1, logic signed [63:0] c2,
                                        logic signed [63:0] c3, logic is_last);
        pending.push_back({azim_q[31:0], elev_q[31:0], range_q, c3[31:0], c2[31:0],
                           c1[31:0], c0[31:0], row});
        pending_last.push_back(is_last);
    endfunction

    function automatic void place_camera(logic signed [63:0] dx, logic signed [63:0] dy,
                                         logic signed [63:0] dz);
        logic [127:0] sq;
        logic [63:0]  ax, ay, az;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        az = (dz < 0) ? -dz : dz;
        if (dx == 0 && dy == 0 && dz == 0) begin
            range_q = 0; elev_q = 0; azim_q = 0;
            return;
        end
        sq = {64'd0, ax} * ax + {64'd0, ay} * ay + {64'd0, az} * az;
        range_q = 33'(root_floor(sq));
        if (dx == 0 && dz == 0) begin
            elev_q = (dy > 0) ? 64'(ocp_pkg::HALF_PI_Q29) : -64'(ocp_pkg::HALF_PI_Q29);
            azim_q = 0;
            return;
        end
        sq = {64'd0, ax} * ax + {64'd0, az} * az;
        elev_q = vector_angle(dy, $signed(root_floor(sq)));
        if (elev_q > ocp_pkg::HALF_PI_Q29) elev_q = ocp_pkg::HALF_PI_Q29;
        if (elev_q < -ocp_pkg::HALF_PI_Q29) elev_q = -ocp_pkg::HALF_PI_Q29;
        azim_q = vector_angle(dx, dz);
    endfunction

    // Notes an accepted request and queues the results it must produce.
    function void note_request(logic [1:0] kind, logic [199:0] d);
        logic signed [63:0] ct, st, cp, sp, acc, tr;
        logic signed [63:0] r[3][3];
        logic signed [63:0] cols[3];
        case (kind)
            ocp_pkg::REQ_SET_POS: begin
                place_camera(64'($signed(d[31:0])) - tgt_x, 64'($signed(d[63:32])) - tgt_y,
                             64'($signed(d[95:64])) - tgt_z);
                push_result(2'd0, 0, 0, 0, 0, 1'b1);
            end
            ocp_pkg::REQ_SET_ORBIT: begin
                range_q = d[128:96];
                elev_q = $signed(d[160:129]);
                azim_q = $signed(d[192:161]);
                push_result(2'd0, 0, 0, 0, 0, 1'b1);
            end
            ocp_pkg::REQ_READ_VIEW: begin
                cos_sin(elev_q, ct, st);
                cos_sin(azim_q, cp, sp);
                r[0][0] = cp; r[0][1] = 0; r[0][2] = -sp;
                r[1][0] = round_q(-st * sp, 30); r[1][1] = ct;
                r[1][2] = round_q(-st * cp, 30);
                r[2][0] = round_q(ct * sp, 30); r[2][1] = st;
                r[2][2] = round_q(ct * cp, 30);
                for (int k = 0; k < 3; k++) begin
                    acc = r[k][0] * tgt_x + r[k][1] * tgt_y + r[k][2] * tgt_z;
                    tr = -round_q(acc, 30);
                    if (k == 2) tr -= $signed({31'd0, range_q});
                    for (int j = 0; j < 3; j++) cols[j] = clip32(round_q(r[k][j], 14));
                    push_result(k[1:0], cols[0], cols[1], cols[2], clip32(tr), k == 2);
                end
            end
            default: ;  // code 3 is dropped by the block
        endcase
    endfunction

    function void report_mismatch(string what, logic [63:0] exp_v, logic [63:0] got_v);
        errors++;
        if (errors <= 40)
            $display("MISMATCH %s: expected %0h got %0h (result %0d)", what, exp_v, got_v,
                     results_seen);
    endfunction

    // Checks one result transfer against the oldest expectation.
    function void check_result(logic [231:0] d, logic lst);
        logic [231:0] e;
        logic         el;
        results_seen++;
        if (pending.size() == 0) begin
            report_mismatch("result with nothing expected", 0, d[31:0]);
            return;
        end
        e = pending.pop_front();
        el = pending_last.pop_front();
        if (d[1:0] != e[1:0]) report_mismatch("row_index", e[1:0], d[1:0]);
        if (d[33:2] != e[33:2]) report_mismatch("col0", e[33:2], d[33:2]);
        if (d[65:34] != e[65:34]) report_mismatch("col1", e[65:34], d[65:34]);
        if (d[97:66] != e[97:66]) report_mismatch("col2", e[97:66], d[97:66]);
        if (d[129:98] != e[129:98]) report_mismatch("col3", e[129:98], d[129:98]);
        if (d[162:130] != e[162:130]) report_mismatch("cur_range", e[162:130], d[162:130]);
        if (d[194:163] != e[194:163])
            report_mismatch("cur_elevation", e[194:163], d[194:163]);
        if (d[226:195] != e[226:195]) report_mismatch("cur_azimuth", e[226:195], d[226:195]);
        if (d[231:227] != 0) report_mismatch("pad", 0, d[231:227]);
        if (lst != el) report_mismatch("tlast", el, lst);
    endfunction
endclass

module tb_orbit_camera_pose_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 350;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [231:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    pose_scoreboard pose_sb;
    int  idle_cycles;
    bit  hold_sink;     // set by the stimulus to ask for one long receiver hold-off
    bit  timed_out;
    int  requests_sent;

    orbit_camera_pose_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // Sends one request and waits for its transfer. The valid stays high across
    // back-to-back requests so it is never lowered and raised in one step.
    task automatic send_request(logic [1:0] kind, logic [199:0] payload);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= payload;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pose_sb.note_request(kind, payload);
        requests_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
    endtask

    // Waits until every expected result has arrived, then lets the pipeline drain.
    task automatic wait_drained();
        stop_sending();
        @(posedge i_clk);
        while (pose_sb.pending.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // Writes one target register; the valid stays high so that writes can follow back
    // to back, and the caller lowers it after the last one.
    task automatic write_target(logic [1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        pose_sb.write_target(idx, val);
    endtask

    function automatic logic [199:0] position_item(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
        logic [199:0] p;
        p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom()};
        p[95:0] = {z, y, x};
        p[199:193] = '0;
        return p;
    endfunction

    function automatic logic [199:0] pose_item(logic [32:0] rng, logic [31:0] el,
                                               logic [31:0] az);
        logic [199:0] p;
        p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
             $urandom()};
        p[192:96] = {az, el, rng};
        p[199:193] = '0;
        return p;
    endfunction

    // Random coordinate: mostly modest values near zero, sometimes full range.
    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom();
        if (r < 3) return 32'($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
        return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endfunction

    function automatic logic [31:0] rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return $urandom();
        return 32'($signed($urandom_range(0, 2 * 1686629713)) - 1686629713);
    endfunction

    function automatic logic [199:0] rand_item(output logic [1:0] kind);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            kind = ocp_pkg::REQ_SET_POS;
            return position_item(rand_coord(), rand_coord(), rand_coord());
        end
        if (r < 60) begin
            kind = ocp_pkg::REQ_SET_ORBIT;
            return pose_item({$urandom_range(0, 1), $urandom()}, rand_angle(), rand_angle());
        end
        if (r < 96) begin
            kind = ocp_pkg::REQ_READ_VIEW;
            return position_item($urandom(), $urandom(), $urandom());
        end
        kind = 2'd3;  // unused code; must be dropped
        return position_item($urandom(), $urandom(), $urandom());
    endfunction

    // Result side: random stalls plus one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                hold_sink = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            pose_sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // Watchdog on cycles with no transfer at all while results are still expected.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || pose_sb.pending.size() == 0) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
                timed_out = 1'b1;
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("orbit_camera_pose_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [1:0]   kind;
        logic [199:0] item;
        logic [31:0]  tx[4];
        pose_sb = new();
        idle_cycles = 0;
        hold_sink = 0;
        timed_out = 0;
        requests_sent = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset pose read, the special cases and the field extremes.
        send_request(ocp_pkg::REQ_READ_VIEW, '0);
        send_request(ocp_pkg::REQ_SET_POS, position_item(0, 0, 0));
        send_request(ocp_pkg::REQ_READ_VIEW, '0);
        send_request(ocp_pkg::REQ_SET_POS, position_item(0, 32'h0003_0000, 0));
        send_request(ocp_pkg::REQ_SET_POS, position_item(0, 32'h8000_0000, 0));
        send_request(ocp_pkg::REQ_READ_VIEW, '0);
        send_request(ocp_pkg::REQ_SET_POS, position_item(32'h7fff_ffff, 32'h7fff_ffff,
                                                         32'h7fff_ffff));
        send_request(ocp_pkg::REQ_SET_POS, position_item(32'h8000_0000, 32'h8000_0000,
                                                         32'h8000_0000));
        send_request(ocp_pkg::REQ_SET_POS, position_item(32'h0001_0000, 0, 32'hffff_0000));
        send_request(ocp_pkg::REQ_SET_POS, position_item(32'hffff_0000, 0, 32'hffff_0000));
        send_request(ocp_pkg::REQ_READ_VIEW, '0);
        send_request(2'd3, position_item($urandom(), $urandom(), $urandom()));
        send_request(ocp_pkg::REQ_SET_ORBIT, pose_item(33'h1_ffff_ffff, 32'h7fff_ffff,
                                                       32'h8000_0000));
        send_request(ocp_pkg::REQ_READ_VIEW, '0);
        send_request(ocp_pkg::REQ_SET_ORBIT, pose_item(0, 32'h8000_0000, 32'h7fff_ffff));
        send_request(ocp_pkg::REQ_READ_VIEW, '0);
        send_request(ocp_pkg::REQ_SET_ORBIT, pose_item(33'd655360, 32'd843314857,
                                                       32'd1686629713));
        send_request(ocp_pkg::REQ_READ_VIEW, {200{1'b1}});
        wait_drained();

        // Random phases, each under its own target: both extremes, then random ones.
        tx = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000};
        for (int ph = 0; ph < 5; ph++) begin
            for (int c = 0; c < 3; c++)
                write_target(c[1:0], (ph < 2) ? tx[ph] : rand_coord());
            if (ph == 2) write_target(ocp_pkg::CFG_TARGET_Y, 32'h0001_0000);
            i_cfg_valid <= 1'b0;
            if (ph == 1) hold_sink = 1'b1;  // long receiver stall while requests keep coming
            for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
                item = rand_item(kind);
                send_request(kind, item);
                if (ph == 3 && n == 30) wait_drained();  // sender waits for every result
            end
            wait_drained();
        end

        $display("Covered %0d requests (position, pose load, view read, unused code) and %0d",
                 requests_sent, pose_sb.results_seen);
        $display("results under zero, extreme and random targets with random stalls.");
        if (pose_sb.errors == 0 && pose_sb.pending.size() == 0) begin
            $display("orbit_camera_pose_unit regression: pass");
        end else begin
            $display("%0d mismatches, %0d results still expected", pose_sb.errors,
                     pose_sb.pending.size());
            $display("orbit_camera_pose_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
